FILE: rtl/dnfc_pkg.sv
// package for the binary64 to narrow float converter
// holds binary64 field constants and the stage-to-stage struct; no dependencies
package dnfc_pkg;

    localparam int DBL_BIAS = 1023;
    localparam int DBL_FRAC = 52;
    localparam int DBL_EXPW = 11;
    localparam int DBL_SIGN = 63;

    localparam logic [6:0] TOTAL_RESET = 7'd32;
    localparam logic [5:0] EXP_RESET   = 6'd8;

    // register indexes of the configuration port
    localparam logic [0:0] REG_TOTAL_WIDTH    = 1'b0;
    localparam logic [0:0] REG_EXPONENT_WIDTH = 1'b1;

    // decoded operand handed from the front stage to the pack stage
    typedef struct packed {
        logic        width_error;
        logic        is_zero;
        logic        is_special;
        logic        is_nan;
        logic        sign;
        logic [52:0] sig;
        logic [5:0]  lead;
        logic signed [13:0] be;
        logic [6:0]  total;
        logic [5:0]  expw;
        logic [6:0]  fracw;
    } dnfc_dec_t;

endpackage

FILE: rtl/dnfc_decode.sv
// front stage: splits the binary64 pattern, normalizes and rebiases the exponent
// depends on dnfc_pkg
module dnfc_decode
    import dnfc_pkg::*;
(
    input  logic [63:0] double_bits,
    input  logic [6:0]  total,
    input  logic [5:0]  expw,
    output dnfc_dec_t   dec
);

    logic [10:0] bexp;
    logic [51:0] frac;
    logic [52:0] sig;
    logic [5:0]  lead;
    logic signed [13:0] ue;
    logic signed [13:0] bias;
    logic        legal;

    always_comb
    begin
        bexp = double_bits[62:52];
        frac = double_bits[51:0];
        sig  = {(bexp != 11'd0), frac};
        // leading one position, 0 when no bit is set
        lead = 6'd0;
        for (int i = 0; i <= 52; i++)
        begin
            if (sig[i])
            begin
                lead = 6'(i);
            end
        end
        legal = (total >= 7'd3) && (total <= 7'd64) && (expw != 6'd0)
                && ({1'b0, expw} <= total - 7'd2);
        ue   = 14'((bexp == 11'd0) ? 14'sd1 : $signed({3'b0, bexp}))
               - 14'sd1023 - 14'sd52 + $signed({8'b0, lead});
        // bias saturates for wide exponents; anything past 2^12 behaves alike
        bias = (expw > 6'd13) ? 14'sd4095
               : 14'((14'sd1 <<< (expw - 6'd1)) - 14'sd1);
        dec.width_error = !legal;
        dec.is_zero     = (bexp == 11'd0) && (frac == 52'd0);
        dec.is_special  = (bexp == 11'h7FF);
        dec.is_nan      = (frac != 52'd0);
        dec.sign        = double_bits[63];
        dec.sig         = sig;
        dec.lead        = lead;
        dec.be          = ue + bias;
        dec.total       = total;
        dec.expw        = expw;
        dec.fracw       = total - {1'b0, expw} - 7'd1;
    end

endmodule

FILE: rtl/dnfc_pack.sv
// back stage: range checks and packs the target pattern
// depends on dnfc_pkg
module dnfc_pack
    import dnfc_pkg::*;
(
    input  dnfc_dec_t   dec,
    output logic [63:0] result,
    output logic        werr
);

    logic [63:0] ones;
    logic [63:0] sgn;
    logic [63:0] fr;
    logic [63:0] mant;
    logic [63:0] exp_field;
    logic        ovf;
    logic signed [14:0] sh;

    always_comb
    begin
        ones = (64'd1 << dec.expw) - 64'd1;
        sgn  = {63'd0, dec.sign} << (dec.total - 7'd1);
        ovf  = (dec.expw > 6'd13) ? 1'b0
               : (dec.be >= $signed({1'b0, ones[12:0]}));
        mant = {11'd0, dec.sig} & ((64'd1 << dec.lead) - 64'd1);
        sh   = 15'(dec.be) - 15'sd1 - $signed({9'd0, dec.lead})
               + $signed({8'd0, dec.fracw});
        // wide formats carry a saturated bias; swap in the true one
        exp_field = (dec.expw > 6'd13)
                    ? 64'(dec.be) - 64'd4095 + ((64'd1 << (dec.expw - 6'd1)) - 64'd1)
                    : 64'(dec.be);
        fr   = 64'd0;
        werr = dec.width_error;
        if (dec.width_error || dec.is_zero)
        begin
            result = 64'd0;
        end
        else if (dec.is_special)
        begin
            result = sgn | (ones << dec.fracw);
            if (dec.is_nan)
            begin
                result = result | (64'd1 << (dec.fracw - 7'd1));
            end
        end
        else if (ovf)
        begin
            result = sgn | (ones << dec.fracw);
        end
        else if (dec.be >= 14'sd1)
        begin
            if ({1'b0, dec.fracw} >= {2'b0, dec.lead})
            begin
                fr = mant << (dec.fracw - {1'b0, dec.lead});
            end
            else
            begin
                fr = mant >> ({1'b0, dec.lead} - dec.fracw);
            end
            result = sgn | (exp_field << dec.fracw) | fr;
        end
        else
        begin
            if (sh >= 15'sd0)
            begin
                fr = {11'd0, dec.sig} << sh[5:0];
            end
            else if (sh <= -15'sd64)
            begin
                fr = 64'd0;
            end
            else
            begin
                fr = {11'd0, dec.sig} >> 6'(-sh);
            end
            result = sgn | fr;
        end
    end

endmodule

FILE: rtl/double_to_narrow_float_convert.sv
// top level of the binary64 to narrow float converter
// depends on dnfc_pkg, dnfc_decode, dnfc_pack
//
// Converts one binary64 pattern per cycle, when not stalled, into a float of
// configured total and exponent width, truncating the fraction. Each beat
// passes through the input register and then the output register, and a new
// beat is taken every cycle while the output side keeps up; when the output
// register holds a beat and out_ready is low, the pipe stalls once the input
// register is also full.
module double_to_narrow_float_convert
    import dnfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] double_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_bits,
    output logic        width_error
);

    logic [6:0]  total_reg;
    logic [5:0]  expw_reg;
    logic        s1_valid_reg;
    dnfc_dec_t   s1_reg;
    dnfc_dec_t   dec;
    logic        s2_valid_reg;
    logic [63:0] res_reg;
    logic        werr_reg;
    logic [63:0] res_next;
    logic        werr_next;
    logic        s2_load;
    logic        s1_load;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= TOTAL_RESET;
            expw_reg  <= EXP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TOTAL_WIDTH:    total_reg <= cfg_data;
                REG_EXPONENT_WIDTH: expw_reg  <= cfg_data[5:0];
                default:            ;
            endcase
        end
    end

    dnfc_decode u_decode (
        .double_bits (double_bits),
        .total       (total_reg),
        .expw        (expw_reg),
        .dec         (dec)
    );

    dnfc_pack u_pack (
        .dec    (s1_reg),
        .result (res_next),
        .werr   (werr_next)
    );

    // pipe advance
    assign s2_load  = !s2_valid_reg || out_ready;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign in_ready = s1_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_load)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            s1_reg <= dec;
        end
        if (s2_load && s1_valid_reg)
        begin
            res_reg  <= res_next;
            werr_reg <= werr_next;
        end
    end

    assign out_valid   = s2_valid_reg;
    assign result_bits = res_reg;
    assign width_error = werr_reg;

endmodule
